/* src/hwt_pkg.sv */
// Shared constants, codes and types of the hierarchical timer wheel.
`default_nettype none
package hwt_pkg;
   localparam int MAX_TIMERS = 64;
   localparam int ROOT_BITS = 8;
   localparam int LEVEL_BITS = 6;
   localparam int NUM_LEVELS = 4;
   localparam int ROOT_SIZE = 1 << ROOT_BITS;
   localparam int LEVEL_SIZE = 1 << LEVEL_BITS;
   localparam int NUM_SLOTS = ROOT_SIZE + NUM_LEVELS * LEVEL_SIZE;
   localparam int MAX_RESULTS = 64;

   localparam int IDX_W = $clog2(MAX_TIMERS);
   localparam int PTR_W = $clog2(MAX_TIMERS + 1);
   localparam int SLOT_W = $clog2(NUM_SLOTS);
   localparam int LVL_W = 2;
   localparam int CNT_W = $clog2(MAX_RESULTS + 1);
   localparam int ID_W = 6;
   localparam int TIME_W = 32;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;
   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 40;

   localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_TIMERS);

   typedef enum logic [KIND_W-1:0] {
      REQ_TICK = 2'd0,
      REQ_ADD  = 2'd1,
      REQ_DEL  = 2'd2
   } req_kind_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK     = 2'd0,
      ST_USED   = 2'd1,
      ST_UNUSED = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      OP_NONE,
      OP_CLR,
      OP_CAPTURE,
      OP_DECODE,
      OP_FILE_A,
      OP_FILE_B,
      OP_UNLINK,
      OP_EMIT_REQ,
      OP_CAS_TAKE,
      OP_CAS_UP,
      OP_ROOT_RD,
      OP_WALK_RD,
      OP_CAS_GOT,
      OP_ROOT_TAKE,
      OP_ROOT_GOT,
      OP_EMIT_EV,
      OP_FREE_ADV,
      OP_ADV,
      OP_TICK_INC
   } op_type;

   typedef enum logic [4:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_FILE_A,
      S_FILE_B,
      S_UNLINK,
      S_EMIT_REQ,
      S_CAS_HEAD,
      S_CAS_LOOP,
      S_CAS_GOT,
      S_CAS_ADV,
      S_ROOT_HEAD,
      S_ROOT_LOOP,
      S_ROOT_GOT,
      S_ROOT_EMIT,
      S_ROOT_ARM,
      S_ROOT_ADV,
      S_TICK_EMPTY,
      S_TICK_END
   } state_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic clr_done;
      logic act_add;
      logic act_del;
      logic is_tick;
      logic idx_zero;
      logic t_nil;
      logic lvl_zero;
      logic lvl_top;
      logic cnt_zero;
      logic cnt_full;
      logic per_zero;
      logic out_free;
   } stat_type;
endpackage
`default_nettype wire

/* src/hwt_ctrl.sv */
// Sequencer of the timer wheel: walks add, delete, cascade and expiry steps.
`default_nettype none
module hwt_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_tvalid,
   output logic                   req_tready,
   input  wire hwt_pkg::stat_type stat,
   output hwt_pkg::cmd_type       cmd
);
   import hwt_pkg::*;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         ret_ff <= S_EMIT_REQ;
      end else begin
         state_ff <= state_in;
         ret_ff <= ret_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      ret_in = ret_ff;
      case (state_ff)
         S_CLEAR: if (stat.clr_done) state_in = S_IDLE;
         S_IDLE: if (req_tvalid) state_in = S_DECODE;
         S_DECODE: begin
            if (stat.act_add) begin
               state_in = S_FILE_A;
               ret_in = S_EMIT_REQ;
            end else if (stat.act_del) begin
               state_in = S_UNLINK;
            end else if (stat.is_tick) begin
               state_in = stat.idx_zero ? S_CAS_HEAD : S_ROOT_HEAD;
            end else begin
               state_in = S_EMIT_REQ;
            end
         end
         S_FILE_A: state_in = S_FILE_B;
         S_FILE_B: state_in = ret_ff;
         S_UNLINK: state_in = S_EMIT_REQ;
         S_EMIT_REQ: if (stat.out_free) state_in = S_IDLE;
         S_CAS_HEAD: state_in = S_CAS_LOOP;
         S_CAS_LOOP: begin
            if (!stat.t_nil) state_in = S_CAS_GOT;
            else if (stat.lvl_zero && !stat.lvl_top) state_in = S_CAS_HEAD;
            else state_in = S_ROOT_HEAD;
         end
         S_CAS_GOT: begin
            state_in = S_FILE_A;
            ret_in = S_CAS_ADV;
         end
         S_CAS_ADV: state_in = S_CAS_LOOP;
         S_ROOT_HEAD: state_in = S_ROOT_LOOP;
         S_ROOT_LOOP: begin
            if (!stat.t_nil) state_in = S_ROOT_GOT;
            else if (stat.cnt_zero) state_in = S_TICK_EMPTY;
            else state_in = S_TICK_END;
         end
         S_ROOT_GOT: state_in = S_ROOT_EMIT;
         S_ROOT_EMIT: if (stat.cnt_full || stat.out_free) state_in = S_ROOT_ARM;
         S_ROOT_ARM: begin
            if (stat.per_zero) begin
               state_in = S_ROOT_LOOP;
            end else begin
               state_in = S_FILE_A;
               ret_in = S_ROOT_ADV;
            end
         end
         S_ROOT_ADV: state_in = S_ROOT_LOOP;
         S_TICK_EMPTY: if (stat.out_free) state_in = S_TICK_END;
         S_TICK_END: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd.op = OP_NONE;
      req_tready = 1'b0;
      case (state_ff)
         S_CLEAR: cmd.op = OP_CLR;
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) cmd.op = OP_CAPTURE;
         end
         S_DECODE: cmd.op = OP_DECODE;
         S_FILE_A: cmd.op = OP_FILE_A;
         S_FILE_B: cmd.op = OP_FILE_B;
         S_UNLINK: cmd.op = OP_UNLINK;
         S_EMIT_REQ: if (stat.out_free) cmd.op = OP_EMIT_REQ;
         S_CAS_HEAD: cmd.op = OP_CAS_TAKE;
         S_CAS_LOOP: begin
            if (!stat.t_nil) cmd.op = OP_WALK_RD;
            else if (stat.lvl_zero && !stat.lvl_top) cmd.op = OP_CAS_UP;
            else cmd.op = OP_ROOT_RD;
         end
         S_CAS_GOT: cmd.op = OP_CAS_GOT;
         S_CAS_ADV: cmd.op = OP_ADV;
         S_ROOT_HEAD: cmd.op = OP_ROOT_TAKE;
         S_ROOT_LOOP: if (!stat.t_nil) cmd.op = OP_WALK_RD;
         S_ROOT_GOT: cmd.op = OP_ROOT_GOT;
         S_ROOT_EMIT: if (!stat.cnt_full && stat.out_free) cmd.op = OP_EMIT_EV;
         S_ROOT_ARM: if (stat.per_zero) cmd.op = OP_FREE_ADV;
         S_ROOT_ADV: cmd.op = OP_ADV;
         S_TICK_EMPTY: if (stat.out_free) cmd.op = OP_EMIT_REQ;
         S_TICK_END: cmd.op = OP_TICK_INC;
         default: cmd.op = OP_NONE;
      endcase
   end
endmodule
`default_nettype wire

/* src/hwt_datapath.sv */
// Datapath of the timer wheel: slot and timer memories, list links, result register.
`default_nettype none
module hwt_datapath (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire hwt_pkg::cmd_type               cmd,
   output hwt_pkg::stat_type                   stat,
   input  wire logic [hwt_pkg::KIND_W-1:0]     req_tuser,
   input  wire logic [hwt_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [hwt_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   output logic                                rsp_tuser,
   output logic                                rsp_tlast
);
   import hwt_pkg::*;

   function automatic logic [LEVEL_BITS-1:0] level_index(input logic [TIME_W-1:0] v,
                                                         input logic [LVL_W-1:0] k);
      logic [TIME_W-1:0] sh;
      sh = v >> (ROOT_BITS + int'(k) * LEVEL_BITS);
      return sh[LEVEL_BITS-1:0];
   endfunction

   function automatic logic [SLOT_W-1:0] cas_slot(input logic [LVL_W-1:0] k,
                                                  input logic [LEVEL_BITS-1:0] idx);
      return SLOT_W'(ROOT_SIZE + int'(k) * LEVEL_SIZE) + SLOT_W'(idx);
   endfunction

   function automatic logic [SLOT_W-1:0] file_slot(input logic [TIME_W-1:0] expv,
                                                   input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0] due;
      logic [SLOT_W-1:0] s;
      due = expv - now;
      if ((due >> ROOT_BITS) == '0)
         s = SLOT_W'(expv[ROOT_BITS-1:0]);
      else if ((due >> (ROOT_BITS + LEVEL_BITS)) == '0)
         s = cas_slot(LVL_W'(0), level_index(expv, LVL_W'(0)));
      else if ((due >> (ROOT_BITS + 2 * LEVEL_BITS)) == '0)
         s = cas_slot(LVL_W'(1), level_index(expv, LVL_W'(1)));
      else if ((due >> (ROOT_BITS + 3 * LEVEL_BITS)) == '0)
         s = cas_slot(LVL_W'(2), level_index(expv, LVL_W'(2)));
      else if (due[TIME_W-1])
         s = SLOT_W'(now[ROOT_BITS-1:0]);
      else
         s = cas_slot(LVL_W'(3), level_index(expv, LVL_W'(3)));
      return s;
   endfunction

   logic [PTR_W-1:0]  head_mem [NUM_SLOTS];
   logic [PTR_W-1:0]  tail_mem [NUM_SLOTS];
   logic [PTR_W-1:0]  next_mem [MAX_TIMERS];
   logic [PTR_W-1:0]  prev_mem [MAX_TIMERS];
   logic [SLOT_W-1:0] slot_mem [MAX_TIMERS];
   logic [TIME_W-1:0] exp_mem  [MAX_TIMERS];
   logic [TIME_W-1:0] per_mem  [MAX_TIMERS];

   logic [PTR_W-1:0]  head_rd_ff, tail_rd_ff, next_rd_ff, prev_rd_ff;
   logic [SLOT_W-1:0] slot_rd_ff;
   logic [TIME_W-1:0] exp_rd_ff, per_rd_ff;

   logic              head_we, tail_we, next_we, prev_we, slot_we, exp_we, per_we;
   logic [SLOT_W-1:0] head_wa, tail_wa, head_ra, tail_ra;
   logic [PTR_W-1:0]  head_wd, tail_wd, next_wd, prev_wd;
   logic [IDX_W-1:0]  next_wa, prev_wa, slot_wa, exp_wa, per_wa, next_ra;
   logic [SLOT_W-1:0] slot_wd;
   logic [TIME_W-1:0] exp_wd;

   logic [KIND_W-1:0]   kind_ff, kind_in;
   logic [ID_W-1:0]     id_ff, id_in;
   logic [TIME_W-1:0]   due_ff, due_in;
   logic [TIME_W-1:0]   reqper_ff, reqper_in;
   logic [TIME_W-1:0]   tick_ff, tick_in;
   logic [TIME_W-1:0]   exp_ff, exp_in;
   logic [PTR_W-1:0]    t_ff, t_in;
   logic [PTR_W-1:0]    nx_ff, nx_in;
   logic [SLOT_W-1:0]   s_ff, s_in;
   logic [LVL_W-1:0]    k_ff, k_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [SLOT_W-1:0]   clr_ff, clr_in;
   logic                per_zero_ff, per_zero_in;
   logic [STAT_W-1:0]   status_ff, status_in;
   logic [MAX_TIMERS-1:0] in_use_ff, in_use_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                rsp_user_ff, rsp_user_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [IDX_W-1:0]  id_idx, t_idx;
   logic              id_bad, id_used, act_add, act_del, out_free;
   logic [STAT_W-1:0] st_code;
   logic [SLOT_W-1:0] root_slot, fslot;
   logic [PTR_W-1:0]  link_p;

   assign id_idx = IDX_W'(id_ff);
   assign t_idx = t_ff[IDX_W-1:0];
   assign id_bad = 32'(id_ff) >= 32'(MAX_TIMERS);
   assign id_used = in_use_ff[id_idx];
   assign act_add = (kind_ff == REQ_ADD) && !id_bad && !id_used;
   assign act_del = (kind_ff == REQ_DEL) && !id_bad && id_used;
   assign root_slot = SLOT_W'(tick_ff[ROOT_BITS-1:0]);
   assign fslot = file_slot(exp_ff, tick_ff);
   assign link_p = (head_rd_ff == NIL) ? NIL : tail_rd_ff;
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      st_code = ST_OK;
      if (kind_ff == REQ_ADD) st_code = id_bad ? ST_UNUSED : (id_used ? ST_USED : ST_OK);
      else if (kind_ff == REQ_DEL) st_code = (id_bad || !id_used) ? ST_UNUSED : ST_OK;
   end

   always_comb begin
      stat.clr_done = clr_ff == SLOT_W'(NUM_SLOTS - 1);
      stat.act_add = act_add;
      stat.act_del = act_del;
      stat.is_tick = kind_ff == REQ_TICK;
      stat.idx_zero = tick_ff[ROOT_BITS-1:0] == '0;
      stat.t_nil = t_ff == NIL;
      stat.lvl_zero = level_index(tick_ff, k_ff) == '0;
      stat.lvl_top = k_ff == LVL_W'(NUM_LEVELS - 1);
      stat.cnt_zero = cnt_ff == '0;
      stat.cnt_full = cnt_ff == CNT_W'(MAX_RESULTS);
      stat.per_zero = per_zero_ff;
      stat.out_free = out_free;
   end

   always_comb begin
      head_we = 1'b0; head_wa = s_ff; head_wd = NIL; head_ra = s_ff;
      tail_we = 1'b0; tail_wa = s_ff; tail_wd = t_ff; tail_ra = s_ff;
      next_we = 1'b0; next_wa = t_idx; next_wd = NIL; next_ra = t_idx;
      prev_we = 1'b0; prev_wa = t_idx; prev_wd = NIL;
      slot_we = 1'b0; slot_wa = t_idx; slot_wd = s_ff;
      exp_we = 1'b0; exp_wa = t_idx; exp_wd = exp_ff;
      per_we = 1'b0; per_wa = id_idx;
      kind_in = kind_ff; id_in = id_ff; due_in = due_ff; reqper_in = reqper_ff;
      tick_in = tick_ff; exp_in = exp_ff; t_in = t_ff; nx_in = nx_ff;
      s_in = s_ff; k_in = k_ff; cnt_in = cnt_ff; clr_in = clr_ff;
      per_zero_in = per_zero_ff; status_in = status_ff; in_use_in = in_use_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_data_in = rsp_data_ff; rsp_user_in = rsp_user_ff; rsp_last_in = rsp_last_ff;
      case (cmd.op)
         OP_CLR: begin
            head_we = 1'b1;
            head_wa = clr_ff;
            clr_in = clr_ff + SLOT_W'(1);
         end
         OP_CAPTURE: begin
            kind_in = req_tuser;
            id_in = req_tdata[ID_W-1:0];
            due_in = req_tdata[ID_W+TIME_W-1:ID_W];
            reqper_in = req_tdata[ID_W+2*TIME_W-1:ID_W+TIME_W];
         end
         OP_DECODE: begin
            status_in = st_code;
            t_in = PTR_W'(id_ff);
            exp_in = tick_ff + due_ff;
            k_in = '0;
            next_ra = id_idx;
            if (act_add) begin
               in_use_in[id_idx] = 1'b1;
               per_we = 1'b1;
               exp_we = 1'b1;
               exp_wa = id_idx;
               exp_wd = tick_ff + due_ff;
            end
            if (act_del) in_use_in[id_idx] = 1'b0;
            s_in = (tick_ff[ROOT_BITS-1:0] == '0) ?
                   cas_slot(LVL_W'(0), level_index(tick_ff, LVL_W'(0))) : root_slot;
            head_ra = s_in;
         end
         OP_FILE_A: begin
            s_in = fslot;
            head_ra = fslot;
            tail_ra = fslot;
            next_we = 1'b1;
         end
         OP_FILE_B: begin
            prev_we = 1'b1;
            prev_wd = link_p;
            slot_we = 1'b1;
            tail_we = 1'b1;
            if (link_p == NIL) begin
               head_we = 1'b1;
               head_wd = t_ff;
            end else begin
               next_we = 1'b1;
               next_wa = link_p[IDX_W-1:0];
               next_wd = t_ff;
            end
         end
         OP_UNLINK: begin
            if (prev_rd_ff == NIL) begin
               head_we = 1'b1;
               head_wa = slot_rd_ff;
               head_wd = next_rd_ff;
            end else begin
               next_we = 1'b1;
               next_wa = prev_rd_ff[IDX_W-1:0];
               next_wd = next_rd_ff;
            end
            if (next_rd_ff == NIL) begin
               tail_we = 1'b1;
               tail_wa = slot_rd_ff;
               tail_wd = prev_rd_ff;
            end else begin
               prev_we = 1'b1;
               prev_wa = next_rd_ff[IDX_W-1:0];
               prev_wd = prev_rd_ff;
            end
         end
         OP_EMIT_REQ: begin
            rsp_valid_in = 1'b1;
            rsp_user_in = 1'b0;
            rsp_last_in = 1'b1;
            rsp_data_in = {tick_ff, status_ff, ID_W'(0)};
         end
         OP_CAS_TAKE: begin
            t_in = head_rd_ff;
            head_we = 1'b1;
         end
         OP_CAS_UP: begin
            k_in = k_ff + LVL_W'(1);
            s_in = cas_slot(k_in, level_index(tick_ff, k_in));
            head_ra = s_in;
         end
         OP_ROOT_RD: begin
            s_in = root_slot;
            head_ra = root_slot;
         end
         OP_WALK_RD: next_ra = t_idx;
         OP_CAS_GOT: begin
            nx_in = next_rd_ff;
            exp_in = exp_rd_ff;
         end
         OP_ROOT_TAKE: begin
            t_in = head_rd_ff;
            head_we = 1'b1;
            cnt_in = '0;
         end
         OP_ROOT_GOT: begin
            nx_in = next_rd_ff;
            per_zero_in = per_rd_ff == '0;
            exp_in = tick_ff + per_rd_ff;
            exp_we = 1'b1;
            exp_wd = tick_ff + per_rd_ff;
         end
         OP_EMIT_EV: begin
            rsp_valid_in = 1'b1;
            rsp_user_in = 1'b1;
            rsp_last_in = (nx_ff == NIL) || (cnt_ff == CNT_W'(MAX_RESULTS - 1));
            rsp_data_in = {tick_ff, STAT_W'(ST_OK), ID_W'(t_ff)};
            cnt_in = cnt_ff + CNT_W'(1);
         end
         OP_FREE_ADV: begin
            in_use_in[t_idx] = 1'b0;
            t_in = nx_ff;
         end
         OP_ADV: t_in = nx_ff;
         OP_TICK_INC: tick_in = tick_ff + TIME_W'(1);
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (head_we) head_mem[head_wa] <= head_wd;
      head_rd_ff <= head_mem[head_ra];
      if (tail_we) tail_mem[tail_wa] <= tail_wd;
      tail_rd_ff <= tail_mem[tail_ra];
      if (next_we) next_mem[next_wa] <= next_wd;
      next_rd_ff <= next_mem[next_ra];
      if (prev_we) prev_mem[prev_wa] <= prev_wd;
      prev_rd_ff <= prev_mem[id_idx];
      if (slot_we) slot_mem[slot_wa] <= slot_wd;
      slot_rd_ff <= slot_mem[id_idx];
      if (exp_we) exp_mem[exp_wa] <= exp_wd;
      exp_rd_ff <= exp_mem[t_idx];
      if (per_we) per_mem[per_wa] <= reqper_ff;
      per_rd_ff <= per_mem[t_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_ff <= '0;
         in_use_ff <= '0;
         clr_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         tick_ff <= tick_in;
         in_use_ff <= in_use_in;
         clr_ff <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff <= kind_in;
      id_ff <= id_in;
      due_ff <= due_in;
      reqper_ff <= reqper_in;
      exp_ff <= exp_in;
      t_ff <= t_in;
      nx_ff <= nx_in;
      s_ff <= s_in;
      k_ff <= k_in;
      cnt_ff <= cnt_in;
      per_zero_ff <= per_zero_in;
      status_ff <= status_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = rsp_data_ff;
   assign rsp_tuser = rsp_user_ff;
   assign rsp_tlast = rsp_last_ff;
endmodule
`default_nettype wire

/* src/hierarchical_timer_wheel.sv */
// Top level of the five-level hierarchical timer wheel.
//
// channel  dir  fields (tdata / tuser, lowest bit first)
// req_     in   tdata: timer_id, due_time, period, pad  tuser: req_type
// rsp_     out  tdata: expired_id, status, tick_now     tuser: event_valid  tlast: last
//
// One word at a time. Add runs decode, two filing steps and the result; delete decode,
// unlink and the result; refused or unknown words skip to the result. A tick re-files
// the timers of each cascaded level, then emits each expired root timer and re-files
// it if periodic. After reset a pass clears all 512 slot heads while req_tready is low.
// A result waits in an output register; a stalled rsp_ side holds the sequencer.
`default_nettype none
module hierarchical_timer_wheel (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [hwt_pkg::REQ_DATA_W-1:0] req_tdata,  // timer_id, due_time, period
   input  wire logic [hwt_pkg::KIND_W-1:0]     req_tuser,  // req_type
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   output logic [hwt_pkg::RSP_DATA_W-1:0]      rsp_tdata,  // expired_id, status, tick_now
   output logic                                rsp_tuser,  // event_valid
   output logic                                rsp_tlast
);
   import hwt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   hwt_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   hwt_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   a_req_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request taken while one is in work");

   a_plain_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tlast)
      else $error("result without expiry not marked last");

   a_event_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[7:6] == ST_OK)
      else $error("expiry word with nonzero status");

   a_idle_while_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");
endmodule
`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for the hierarchical timer wheel: predictor, scoreboard and stimulus.
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import hwt_pkg::*;

   localparam logic [KIND_W-1:0] REQ_UNKNOWN = 2'd3;
   localparam int LIMIT = 20000000;
   localparam int NONE = MAX_TIMERS;

   typedef struct {
      logic       ev;
      logic [5:0] id;
      status_type st;
      logic       lst;
      logic [31:0] tick;
   } expiry_word_type;

   class wheel_scoreboard;
      logic [31:0] now_tick;
      logic [31:0] due_at [MAX_TIMERS];
      logic [31:0] rearm [MAX_TIMERS];
      bit          busy [MAX_TIMERS];
      int          nxt [MAX_TIMERS];
      int          prv [MAX_TIMERS];
      int          home [MAX_TIMERS];
      int          head [NUM_SLOTS];
      int          tail [NUM_SLOTS];
      expiry_word_type pending_q[$];
      int          errors;
      int          fired;
      int          ticks;

      function new();
         now_tick = 0;
         errors = 0;
         fired = 0;
         ticks = 0;
         foreach (busy[i]) busy[i] = 0;
         foreach (head[i]) begin
            head[i] = NONE;
            tail[i] = NONE;
         end
      endfunction

      function void append(int t, int s);
         prv[t] = tail[s];
         nxt[t] = NONE;
         if (tail[s] == NONE) head[s] = t;
         else nxt[tail[s]] = t;
         tail[s] = t;
         home[t] = s;
      endfunction

      function void unlink(int t);
         if (prv[t] == NONE) head[home[t]] = nxt[t];
         else nxt[prv[t]] = nxt[t];
         if (nxt[t] == NONE) tail[home[t]] = prv[t];
         else prv[nxt[t]] = prv[t];
      endfunction

      function void place(int t);
         logic [31:0] e;
         logic [31:0] d;
         int s;
         e = due_at[t];
         d = e - now_tick;
         if (d < 32'd256) s = int'(e[7:0]);
         else if (d < 32'd16384) s = ROOT_SIZE + int'(e[13:8]);
         else if (d < 32'd1048576) s = ROOT_SIZE + LEVEL_SIZE + int'(e[19:14]);
         else if (d < 32'd67108864) s = ROOT_SIZE + 2 * LEVEL_SIZE + int'(e[25:20]);
         else if (d[31]) s = int'(now_tick[7:0]);
         else s = ROOT_SIZE + 3 * LEVEL_SIZE + int'(e[31:26]);
         append(t, s);
      endfunction

      function void cascade(int k, int idx);
         int s;
         int t;
         int n;
         s = ROOT_SIZE + k * LEVEL_SIZE + idx;
         t = head[s];
         head[s] = NONE;
         tail[s] = NONE;
         while (t != NONE) begin
            n = nxt[t];
            place(t);
            t = n;
         end
      endfunction

      function void push(logic ev, int id, status_type st);
         expiry_word_type w;
         w.ev = ev;
         w.id = id[5:0];
         w.st = st;
         w.lst = 1'b0;
         w.tick = now_tick;
         pending_q.push_back(w);
      endfunction

      function void note(logic [1:0] kind, logic [5:0] id, logic [31:0] due,
                         logic [31:0] per);
         status_type st;
         int idx;
         int t;
         int n;
         int cnt;
         cnt = 0;
         case (kind)
            REQ_ADD: begin
               if (busy[id]) st = ST_USED;
               else begin
                  busy[id] = 1;
                  rearm[id] = per;
                  due_at[id] = now_tick + due;
                  place(int'(id));
                  st = ST_OK;
               end
               push(1'b0, 0, st);
            end
            REQ_DEL: begin
               if (busy[id]) begin
                  unlink(int'(id));
                  busy[id] = 0;
                  st = ST_OK;
               end else st = ST_UNUSED;
               push(1'b0, 0, st);
            end
            REQ_TICK: begin
               ticks++;
               idx = int'(now_tick[7:0]);
               if (idx == 0) begin
                  cascade(0, int'(now_tick[13:8]));
                  if (now_tick[13:8] == 6'd0) begin
                     cascade(1, int'(now_tick[19:14]));
                     if (now_tick[19:14] == 6'd0) begin
                        cascade(2, int'(now_tick[25:20]));
                        if (now_tick[25:20] == 6'd0) cascade(3, int'(now_tick[31:26]));
                     end
                  end
               end
               t = head[idx];
               head[idx] = NONE;
               tail[idx] = NONE;
               while (t != NONE) begin
                  n = nxt[t];
                  if (cnt < MAX_RESULTS) begin
                     push(1'b1, t, ST_OK);
                     cnt++;
                     fired++;
                  end
                  if (rearm[t] != 0) begin
                     due_at[t] = now_tick + rearm[t];
                     place(t);
                  end else busy[t] = 0;
                  t = n;
               end
               if (cnt == 0) push(1'b0, 0, ST_OK);
            end
            default: push(1'b0, 0, ST_OK);
         endcase
         pending_q[pending_q.size()-1].lst = 1'b1;
         if (kind == REQ_TICK) now_tick++;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $realtime, what);
         errors++;
      endtask

      task check(logic ev, logic [5:0] id, logic [1:0] st, logic lst, logic [31:0] tick);
         expiry_word_type w;
         if (pending_q.size() == 0) begin
            report("result word with nothing outstanding");
            return;
         end
         w = pending_q.pop_front();
         if (ev !== w.ev || id !== w.id || st !== w.st || lst !== w.lst || tick !== w.tick)
            report($sformatf({"got ev%0b id%0d st%0d last%0b tick%0d, ",
                              "want ev%0b id%0d st%0d last%0b tick%0d"},
                             ev, id, st, lst, tick, w.ev, w.id, w.st, w.lst, w.tick));
      endtask
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [KIND_W-1:0] req_tuser = REQ_TICK;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   wheel_scoreboard sb = new();
   int sent = 0;
   int cycles = 0;
   bit calm = 0;
   bit hold_done = 0;

   hierarchical_timer_wheel dut (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   int hold_left = 0;
   always @(posedge clock) begin
      if (rsp_tvalid && rsp_tready)
         sb.check(rsp_tuser, rsp_tdata[5:0], rsp_tdata[7:6], rsp_tlast, rsp_tdata[39:8]);
      if (!hold_done && sent == 150) begin
         hold_done <= 1;
         hold_left <= 600;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else
         rsp_tready <= calm || $urandom_range(99) >= 15;
   end

   task automatic send(logic [1:0] kind, logic [5:0] id, logic [31:0] due, logic [31:0] per);
      while (!calm && $urandom_range(99) < 15) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tvalid <= 1;
      req_tuser <= kind;
      req_tdata <= {2'b00, per, due, id};
      do @(posedge clock); while (!req_tready);
      sb.note(kind, id, due, per);
      sent++;
   endtask

   function automatic logic [31:0] pick_due();
      int r;
      r = $urandom_range(99);
      if (r < 60) return $urandom_range(40);
      if (r < 75) return $urandom_range(300);
      if (r < 85) return $urandom_range(20000);
      if (r < 92) return {1'b1, 31'($urandom)};
      return $urandom;
   endfunction

   task automatic random_item();
      int r;
      logic [31:0] per;
      r = $urandom_range(99);
      per = ($urandom_range(99) < 55) ? 32'd0 : pick_due();
      if (r < 50) send(REQ_TICK, 6'($urandom), $urandom, $urandom);
      else if (r < 80) send(REQ_ADD, 6'($urandom), pick_due(), per);
      else if (r < 96) send(REQ_DEL, 6'($urandom), $urandom, $urandom);
      else send(REQ_UNKNOWN, 6'($urandom), $urandom, $urandom);
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 0;
      send(REQ_TICK, 6'd0, 32'd0, 32'd0);
      send(REQ_ADD, 6'd0, 32'd0, 32'd0);
      send(REQ_ADD, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send(REQ_ADD, 6'd0, 32'd5, 32'd0);
      send(REQ_DEL, 6'd5, 32'd0, 32'd0);
      send(REQ_ADD, 6'd1, 32'd1, 32'd1);
      send(REQ_ADD, 6'd2, 32'h8000_0000, 32'd0);
      send(REQ_ADD, 6'd3, 32'd256, 32'd0);
      send(REQ_ADD, 6'd4, 32'd16384, 32'd0);
      send(REQ_ADD, 6'd5, 32'd2, 32'h8000_0001);
      send(REQ_UNKNOWN, 6'h2A, 32'h5555_5555, 32'hAAAA_AAAA);
      repeat (4) send(REQ_TICK, 6'd0, 32'd0, 32'd0);
      send(REQ_DEL, 6'd63, 32'd0, 32'd0);
      send(REQ_DEL, 6'd63, 32'd0, 32'd0);
      send(REQ_DEL, 6'd1, 32'd0, 32'd0);
      for (int i = 0; i < 400; i++) begin
         calm = (i >= 300 && i < 380);
         random_item();
         if (i == 220) begin
            req_tvalid <= 0;
            while (sb.pending_q.size() != 0) @(posedge clock);
         end
      end
      calm = 0;
      for (int i = 0; i < 100; i++) send(REQ_TICK, 6'd0, 32'd0, 32'd0);
      req_tvalid <= 0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("covered %0d words, %0d ticks reaching tick %0d, %0d expiries",
               sent, sb.ticks, sb.now_tick, sb.fired);
      if (sb.errors == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end
endmodule
`default_nettype wire
